>>> src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

	// Framing bytes
	localparam logic [7:0] START_BYTE     = 8'h5A;
	localparam logic [7:0] TYPE_ACK       = 8'hA1;
	localparam logic [7:0] TYPE_NAK       = 8'hA2;
	localparam logic [7:0] TYPE_CMD       = 8'hA4;
	localparam logic [7:0] TYPE_DATA      = 8'hA5;
	localparam logic [7:0] TYPE_PING      = 8'hA6;
	localparam logic [7:0] TYPE_PING_RESP = 8'hA7;

	// CRC-16, poly 0x1021, MSB first
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	// Frame size limit register
	localparam int          LIMIT_W     = 12;
	localparam logic [11:0] LIMIT_RESET = 12'd2048;
	localparam logic [16:0] HARD_LIMIT  = 17'd2048;
	localparam int          ADDR_W      = 3;
	localparam logic        REG_FRAME_SIZE_LIMIT = 1'b0;

	// Fixed frame sizes
	localparam logic [10:0] PING_RESP_TOTAL = 11'd10;
	localparam logic [10:0] HEADER_TOTAL    = 11'd6;

	// Input stage contents
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} bfr_stage_t;

	// One result item
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_end;
		logic       crc_good;
		logic [7:0] frame_type;
		logic       response_event;
	} bfr_result_t;

	// One byte of CRC, eight bit steps unrolled
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/bfr_if.sv
`default_nettype none

// Received byte channel
interface bfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface bfr_out_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       frame_end;
	logic       crc_good;
	logic [7:0] frame_type;
	logic       response_event;

	modport source (output valid, output payload_valid, output payload_byte,
		output frame_end, output crc_good, output frame_type, output response_event,
		input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input frame_end, input crc_good, input frame_type, input response_event,
		output ready);
endinterface

`default_nettype wire

>>> src/boot_frame_receiver_crc16.sv
// Serial bootloader frame receiver with CRC-16 (poly 0x1021, init 0) check.
// Feed one received byte per rx transaction; each byte yields exactly one
// result transaction on frame, carrying payload bytes of data frames, the
// frame type, frame end with CRC status, and a response event. Each byte
// goes through the input register, then parser and CRC byte update into the
// result register, and a new byte is accepted every cycle as long as results
// are taken; frame.ready stalls both registers.
// frame_size_limit sits at byte address 0 of the APB port and should only be
// written while no bytes are in flight. Payload is streamed, not buffered:
// drop it downstream when the closing result shows crc_good low.
`default_nettype none

module boot_frame_receiver_crc16 (
	input  wire                         clk,
	input  wire                         arst_n,
	bfr_in_if.sink                      rx,
	bfr_out_if.source                   frame,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [bfr_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [bfr_pkg::LIMIT_W-1:0] frame_size_limit;
	bfr_pkg::bfr_stage_t         stage;
	logic                        take;

	// Configuration registers
	bfr_apb_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.frame_size_limit (frame_size_limit)
	);

	// Input register
	bfr_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.stage  (stage)
	);

	// Parser, CRC and result register
	bfr_decode u_dec (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame_size_limit (frame_size_limit),
		.stage            (stage),
		.take             (take),
		.frame            (frame)
	);

endmodule

`default_nettype wire

>>> src/bfr_apb_regs.sv
`default_nettype none

module bfr_apb_regs (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [bfr_pkg::ADDR_W-1:0]    paddr,
	input  wire  [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [bfr_pkg::LIMIT_W-1:0]   frame_size_limit
);

	logic [bfr_pkg::LIMIT_W-1:0] limit_q;
	logic                        hit;

	// Word decode: register index is the address above the byte lane bits
	assign hit    = (paddr[bfr_pkg::ADDR_W-1] == bfr_pkg::REG_FRAME_SIZE_LIMIT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bfr_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			limit_q <= pwdata[bfr_pkg::LIMIT_W-1:0];
		end
	end

	// Readback
	always_comb begin
		prdata = 32'h0;
		if (hit) begin
			prdata = {{(32-bfr_pkg::LIMIT_W){1'b0}}, limit_q};
		end
	end

	assign frame_size_limit = limit_q;

endmodule

`default_nettype wire

>>> src/bfr_in_stage.sv
`default_nettype none

module bfr_in_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	bfr_in_if.sink               rx,
	input  wire                  take,
	output bfr_pkg::bfr_stage_t  stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// Stage is free when empty or being drained this cycle
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

`default_nettype wire

>>> src/bfr_decode.sv
`default_nettype none

module bfr_decode (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [bfr_pkg::LIMIT_W-1:0]  frame_size_limit,
	input  wire  bfr_pkg::bfr_stage_t    stage,
	output logic                         take,
	bfr_out_if.source                    frame
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_CRC_LO = 3'd4;
	localparam logic [2:0] PH_CRC_HI = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;

	logic [2:0]  phase_q,        phase_d;
	logic [10:0] byte_index_q,   byte_index_d;
	logic [10:0] frame_total_q,  frame_total_d;
	logic [7:0]  length_low_q,   length_low_d;
	logic [15:0] crc_running_q,  crc_running_d;
	logic [15:0] crc_stored_q,   crc_stored_d;
	logic [7:0]  type_held_q,    type_held_d;

	logic                 out_valid_q;
	bfr_pkg::bfr_result_t res_q;
	bfr_pkg::bfr_result_t res_d;

	logic [7:0]  b;
	logic [15:0] crc_upd;
	logic [15:0] crc_hi_stored;
	logic [16:0] total;
	logic [11:0] next_index;

	// Move the staged byte when the result register is free or draining
	assign take = stage.valid && (!out_valid_q || frame.ready);

	assign b             = stage.rx_byte;
	assign crc_upd       = bfr_pkg::crc_byte(crc_running_q, b);
	assign crc_hi_stored = {b, crc_stored_q[7:0]};
	assign total         = {1'b0, b, length_low_q} + 17'd6;
	assign next_index    = {1'b0, byte_index_q} + 12'd1;

	// Frame parser: next state and result for the staged byte
	always_comb begin
		phase_d       = phase_q;
		byte_index_d  = byte_index_q;
		frame_total_d = frame_total_q;
		length_low_d  = length_low_q;
		crc_running_d = crc_running_q;
		crc_stored_d  = crc_stored_q;
		type_held_d   = type_held_q;
		res_d         = '0;

		unique case (phase_q)
			PH_TYPE: begin
				unique case (b) inside
					bfr_pkg::TYPE_CMD, bfr_pkg::TYPE_DATA,
					bfr_pkg::TYPE_PING_RESP: begin
						res_d.frame_type = b;
						type_held_d      = b;
						crc_running_d    = crc_upd;
						byte_index_d     = 11'd2;
						if (b == bfr_pkg::TYPE_PING_RESP) begin
							frame_total_d        = bfr_pkg::PING_RESP_TOTAL;
							res_d.response_event = 1'b1;
						end
						phase_d = PH_LEN_LO;
					end
					bfr_pkg::TYPE_PING: begin
						res_d.frame_type     = b;
						res_d.response_event = 1'b1;
						phase_d              = PH_IDLE;
					end
					bfr_pkg::TYPE_ACK, bfr_pkg::TYPE_NAK: begin
						res_d.frame_type = b;
						phase_d          = PH_IDLE;
					end
					default: begin
						// unknown type: keep waiting for a type byte
					end
				endcase
			end
			PH_LEN_LO: begin
				res_d.frame_type = type_held_q;
				crc_running_d    = crc_upd;
				length_low_d     = b;
				byte_index_d     = 11'd3;
				phase_d          = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				res_d.frame_type = type_held_q;
				crc_running_d    = crc_upd;
				// oversized frames are marked by a zero total
				if (type_held_q != bfr_pkg::TYPE_PING_RESP) begin
					if (total < {5'd0, frame_size_limit} && total < bfr_pkg::HARD_LIMIT) begin
						frame_total_d = total[10:0];
					end else begin
						frame_total_d = 11'd0;
					end
				end
				byte_index_d = 11'd4;
				phase_d      = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				res_d.frame_type = type_held_q;
				crc_stored_d     = {8'h00, b};
				byte_index_d     = 11'd5;
				phase_d          = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				res_d.frame_type = type_held_q;
				crc_stored_d     = crc_hi_stored;
				byte_index_d     = 11'd6;
				if (frame_total_q == 11'd0) begin
					phase_d     = PH_IDLE;
					type_held_d = 8'h00;
				end else if (frame_total_q == bfr_pkg::HEADER_TOTAL) begin
					// zero-length frame closes here
					res_d.frame_end      = 1'b1;
					res_d.crc_good       = (crc_running_q == crc_hi_stored);
					res_d.response_event = (crc_running_q == crc_hi_stored);
					phase_d              = PH_IDLE;
					type_held_d          = 8'h00;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res_d.frame_type = type_held_q;
				crc_running_d    = crc_upd;
				if (type_held_q == bfr_pkg::TYPE_DATA) begin
					res_d.payload_valid = 1'b1;
					res_d.payload_byte  = b;
				end
				if (next_index >= {1'b0, frame_total_q}) begin
					res_d.frame_end      = 1'b1;
					res_d.crc_good       = (crc_upd == crc_stored_q);
					res_d.response_event = (crc_upd == crc_stored_q);
					phase_d              = PH_IDLE;
					type_held_d          = 8'h00;
				end else begin
					byte_index_d = next_index[10:0];
				end
			end
			default: begin
				// idle, and any unused code: hunt for the start byte
				phase_d = PH_IDLE;
				if (b == bfr_pkg::START_BYTE) begin
					crc_running_d = bfr_pkg::crc_byte(16'h0000, b);
					byte_index_d  = 11'd1;
					frame_total_d = 11'd0;
					length_low_d  = 8'h00;
					crc_stored_d  = 16'h0000;
					type_held_d   = 8'h00;
					phase_d       = PH_TYPE;
				end
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_index_q  <= 11'd0;
			frame_total_q <= 11'd0;
			length_low_q  <= 8'h00;
			crc_running_q <= 16'h0000;
			crc_stored_q  <= 16'h0000;
			type_held_q   <= 8'h00;
		end else if (take) begin
			phase_q       <= phase_d;
			byte_index_q  <= byte_index_d;
			frame_total_q <= frame_total_d;
			length_low_q  <= length_low_d;
			crc_running_q <= crc_running_d;
			crc_stored_q  <= crc_stored_d;
			type_held_q   <= type_held_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.payload_valid  = res_q.payload_valid;
	assign frame.payload_byte   = res_q.payload_byte;
	assign frame.frame_end      = res_q.frame_end;
	assign frame.crc_good       = res_q.crc_good;
	assign frame.frame_type     = res_q.frame_type;
	assign frame.response_event = res_q.response_event;

endmodule

`default_nettype wire

>>> src/bfr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bfr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire       payload_valid,
	input wire       frame_end,
	input wire       crc_good,
	input wire [7:0] frame_type,
	input wire       response_event
);

	// A stalled result stays offered
	`BFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// Payload only comes from data frames
	`BFR_ASSERT_NOW(a_payload_type, clk, arst_n, out_valid && payload_valid, frame_type == bfr_pkg::TYPE_DATA)

	// CRC status is only reported at a frame end
	`BFR_ASSERT_NOW(a_good_at_end, clk, arst_n, out_valid && crc_good, frame_end)

	// A frame end responds exactly when its CRC is good
	`BFR_ASSERT_NOW(a_end_resp, clk, arst_n, out_valid && frame_end, response_event == crc_good)

endmodule

bind boot_frame_receiver_crc16 bfr_checker u_bfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (frame.valid),
	.out_ready      (frame.ready),
	.payload_valid  (frame.payload_valid),
	.frame_end      (frame.frame_end),
	.crc_good       (frame.crc_good),
	.frame_type     (frame.frame_type),
	.response_event (frame.response_event)
);

`default_nettype wire
